FILE: hdl/rsam_pkg.sv
`default_nettype none
package rsam_pkg;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 32;
    localparam int FRAC_W   = 26;
    localparam int STEP_W   = 24;
    localparam int Q_W      = 48;
    localparam logic [FRAC_W-1:0] ONE_Q16 = 26'h10000;

    typedef enum logic {
        OP_MAIN   = 1'b0,
        OP_COPROC = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_COPROC_ON  = 1'b0,
        REG_STEP_RATIO = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIV,
        ST_PUSH,
        ST_POP,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctrl_t;
endpackage
`default_nettype wire

FILE: hdl/rsam_ram.sv
`default_nettype none
module rsam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/rsam_lane.sv
`default_nettype none
// One channel lane: restoring signed division of sum*65536 by step,
// one quotient bit per cycle while ctrl.busy is high, then clamp to 16 bits.
module rsam_lane
    import rsam_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire div_ctrl_t                  ctrl,
    input  wire logic signed [SUM_W-1:0]    sum,
    input  wire logic        [STEP_W-1:0]   step,
    output logic signed      [SAMPLE_W-1:0] result
);
    logic [Q_W-1:0]    quo_reg, quo_next;
    logic [STEP_W:0]   rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic [STEP_W:0]   trial;
    logic [Q_W-1:0]    mag;
    logic signed [Q_W:0] sq;

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        trial    = {rem_reg[STEP_W-1:0], quo_reg[Q_W-1]};
        if (ctrl.start) begin
            neg_next = sum[SUM_W-1];
            quo_next = {(sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum)), 16'h0};
            rem_next = '0;
        end else if (ctrl.busy) begin
            if (trial >= {1'b0, step}) begin
                rem_next = trial - {1'b0, step};
                quo_next = {quo_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_reg <= 1'b0;
        end else begin
            neg_reg <= neg_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign mag = quo_reg;
    assign sq  = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_comb begin
        if (sq > 32767) begin
            result = 16'sh7fff;
        end else if (sq < -32768) begin
            result = -16'sh8000;
        end else begin
            result = sq[SAMPLE_W-1:0];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/resampling_stereo_audio_mixer.sv
`default_nettype none
// Flow: a passthrough item is registered to the output the cycle after accept;
// queued main items pass PROD and POP, then READ and OUT when both queues hold
// data; a coprocessor item that closes an output period adds DIV (bit-serial
// divider per lane) and PUSH. One item at a time: s_ready is low outside IDLE.
// Reset: synchronous active-low; queues empty, sums and fraction zero,
// coprocessor off, step 1.0. Queue RAM is not cleared; counts gate reads.
module resampling_stereo_audio_mixer
    import rsam_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_operation,
    input  wire logic signed [SAMPLE_W-1:0] s_left_sample,
    input  wire logic signed [SAMPLE_W-1:0] s_right_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_mixed_left,
    output logic signed [SAMPLE_W-1:0]      m_mixed_right
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = AW + 1;
    localparam int DIV_CYC = Q_W;
    localparam int DCW = $clog2(DIV_CYC + 1);

    state_t state_reg, state_next;

    logic              on_reg;
    logic [STEP_W-1:0] step_reg;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [SUM_W-1:0]  suml_reg, suml_next, sumr_reg, sumr_next;
    logic [AW-1:0]     mrd_reg, mrd_next, mwr_reg, mwr_next;
    logic [AW-1:0]     crd_reg, crd_next, cwr_reg, cwr_next;
    logic [CW-1:0]     mcnt_reg, mcnt_next, ccnt_reg, ccnt_next;
    logic [DCW-1:0]    dcnt_reg, dcnt_next;

    // held input item
    logic              op_reg;
    logic signed [SAMPLE_W-1:0] inl_reg, inr_reg;
    // products (registered after multiply)
    logic [SUM_W-1:0]  pla_reg, pra_reg, plb_reg, prb_reg;
    logic [FRAC_W-1:0] first_reg;

    logic              ov_reg, ov_next;
    logic [SAMPLE_W-1:0] ol_reg, ol_next, or_reg, or_next;

    logic [STEP_W-1:0] step_eff;
    logic              wr_cfg;
    div_ctrl_t         dctl;
    logic signed [SAMPLE_W-1:0] divl, divr;
    logic              mwe, cwe;
    logic [31:0]       mwdata, cwdata, mrdata, crdata;
    logic              out_free;

    assign pready   = 1'b1;
    assign wr_cfg   = psel && penable && pwrite;
    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;
    assign out_free = !ov_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign m_valid  = ov_reg;
    assign m_mixed_left  = ol_reg;
    assign m_mixed_right = or_reg;

    always_comb begin
        unique case (paddr[2])
            REG_COPROC_ON:  prdata = {31'h0, on_reg};
            REG_STEP_RATIO: prdata = {8'h0, step_reg};
            default:        prdata = '0;
        endcase
    end

    // queue pointer advance, wrapping at the queue depth
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        begin
            ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
        end
    endfunction

    // signed x times unsigned Q.16 weight, truncated toward zero
    function automatic logic [SUM_W-1:0] tprod(input logic signed [SAMPLE_W-1:0] x,
                                               input logic [FRAC_W-1:0] w);
        logic signed [SAMPLE_W+FRAC_W:0] p;
        logic signed [SAMPLE_W+FRAC_W:0] q;
        begin
            p = x * $signed({1'b0, w});
            q = p >>> 16;
            if (p[SAMPLE_W+FRAC_W] && (p[15:0] != '0)) begin
                q = q + 1;
            end
            tprod = q[SUM_W-1:0];
        end
    endfunction

    assign dctl.start = (state_reg == ST_PROD) && (frac_reg < ONE_Q16);
    assign dctl.busy  = (state_reg == ST_DIV);

    rsam_lane u_lane_l (
        .aclk(aclk), .aresetn(aresetn), .ctrl(dctl),
        .sum(suml_next), .step(step_eff), .result(divl)
    );
    rsam_lane u_lane_r (
        .aclk(aclk), .aresetn(aresetn), .ctrl(dctl),
        .sum(sumr_next), .step(step_eff), .result(divr)
    );

    rsam_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_main_q (
        .aclk(aclk), .we(mwe), .waddr(mwr_reg), .wdata(mwdata),
        .raddr(mrd_reg), .rdata(mrdata)
    );
    rsam_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_coproc_q (
        .aclk(aclk), .we(cwe), .waddr(cwr_reg), .wdata(cwdata),
        .raddr(crd_reg), .rdata(crdata)
    );

    assign mwdata = {inr_reg, inl_reg};
    assign cwdata = {divr, divl};

    // merge stage: average of the two queue heads, truncated toward zero
    function automatic logic [SAMPLE_W-1:0] avg(input logic [SAMPLE_W-1:0] a,
                                                input logic [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W:0] s;
        begin
            s = $signed({a[SAMPLE_W-1], a}) + $signed({b[SAMPLE_W-1], b});
            if (s[SAMPLE_W]) begin
                s = s + 1;
            end
            avg = s[SAMPLE_W:1];
        end
    endfunction

    always_comb begin
        state_next = state_reg;
        frac_next  = frac_reg;
        suml_next  = suml_reg;
        sumr_next  = sumr_reg;
        mrd_next   = mrd_reg;
        mwr_next   = mwr_reg;
        crd_next   = crd_reg;
        cwr_next   = cwr_reg;
        mcnt_next  = mcnt_reg;
        ccnt_next  = ccnt_reg;
        dcnt_next  = dcnt_reg;
        ov_next    = ov_reg && !m_ready;
        ol_next    = ol_reg;
        or_next    = or_reg;
        mwe        = 1'b0;
        cwe        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_operation == OP_MAIN && !on_reg) begin
                        ov_next = 1'b1;
                        ol_next = s_left_sample;
                        or_next = s_right_sample;
                    end else begin
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD: begin
                if (op_reg == OP_MAIN) begin
                    if (mcnt_reg != CW'(QUEUE_DEPTH)) begin
                        mwe       = 1'b1;
                        mwr_next  = ptr_inc(mwr_reg);
                        mcnt_next = mcnt_reg + CW'(1);
                    end
                    state_next = ST_POP;
                end else if (frac_reg >= ONE_Q16) begin
                    frac_next  = frac_reg - ONE_Q16;
                    suml_next  = suml_reg + SUM_W'(inl_reg);
                    sumr_next  = sumr_reg + SUM_W'(inr_reg);
                    state_next = ST_POP;
                end else begin
                    suml_next  = suml_reg + pla_reg;
                    sumr_next  = sumr_reg + pra_reg;
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(DIV_CYC - 1)) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                suml_next = plb_reg;
                sumr_next = prb_reg;
                frac_next = ({2'b0, step_eff} >= first_reg)
                          ? ({2'b0, step_eff} - first_reg) : '0;
                if (ccnt_reg != CW'(QUEUE_DEPTH)) begin
                    cwe       = 1'b1;
                    cwr_next  = ptr_inc(cwr_reg);
                    ccnt_next = ccnt_reg + CW'(1);
                end
                state_next = ST_POP;
            end
            ST_POP: begin
                state_next = (mcnt_reg != '0 && ccnt_reg != '0) ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    ov_next   = 1'b1;
                    ol_next   = avg(mrdata[15:0], crdata[15:0]);
                    or_next   = avg(mrdata[31:16], crdata[31:16]);
                    mrd_next  = ptr_inc(mrd_reg);
                    crd_next  = ptr_inc(crd_reg);
                    mcnt_next = mcnt_reg - CW'(1);
                    ccnt_next = ccnt_reg - CW'(1);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (wr_cfg) begin
            unique case (paddr[2])
                REG_COPROC_ON: begin
                    mrd_next = '0; mwr_next = '0; mcnt_next = '0;
                    crd_next = '0; cwr_next = '0; ccnt_next = '0;
                    suml_next = '0; sumr_next = '0;
                end
                REG_STEP_RATIO: frac_next = '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            on_reg    <= 1'b0;
            step_reg  <= STEP_W'(ONE_Q16);
            frac_reg  <= '0;
            suml_reg  <= '0;
            sumr_reg  <= '0;
            mrd_reg   <= '0;
            mwr_reg   <= '0;
            crd_reg   <= '0;
            cwr_reg   <= '0;
            mcnt_reg  <= '0;
            ccnt_reg  <= '0;
            dcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            frac_reg  <= frac_next;
            suml_reg  <= suml_next;
            sumr_reg  <= sumr_next;
            mrd_reg   <= mrd_next;
            mwr_reg   <= mwr_next;
            crd_reg   <= crd_next;
            cwr_reg   <= cwr_next;
            mcnt_reg  <= mcnt_next;
            ccnt_reg  <= ccnt_next;
            dcnt_reg  <= dcnt_next;
            ov_reg    <= ov_next;
            if (wr_cfg && paddr[2] == REG_COPROC_ON) begin
                on_reg <= pwdata[0];
            end
            if (wr_cfg && paddr[2] == REG_STEP_RATIO) begin
                step_reg <= pwdata[STEP_W-1:0];
            end
        end
        ol_reg <= ol_next;
        or_reg <= or_next;
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            inl_reg <= s_left_sample;
            inr_reg <= s_right_sample;
            // weights use the fraction held at accept time
            pla_reg   <= tprod(s_left_sample, frac_reg);
            pra_reg   <= tprod(s_right_sample, frac_reg);
            plb_reg   <= tprod(s_left_sample, ONE_Q16 - frac_reg);
            prb_reg   <= tprod(s_right_sample, ONE_Q16 - frac_reg);
            first_reg <= ONE_Q16 - frac_reg;
        end
    end
endmodule
`default_nettype wire

FILE: verif/resampling_stereo_audio_mixer_tb.sv
`timescale 1ns / 100ps
module resampling_stereo_audio_mixer_tb;
    import rsam_pkg::*;

    localparam int QDEPTH = 256;
    // Register byte addresses: index * 4.
    localparam logic [2:0] ADDR_COPROC_ON  = 3'(int'(REG_COPROC_ON) * 4);
    localparam logic [2:0] ADDR_STEP_RATIO = 3'(int'(REG_STEP_RATIO) * 4);
    // Settle margin that drain waits after the last expected result.
    localparam int SETTLE_CYCLES = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = 1'b0;
    logic signed [15:0] s_left_sample = '0, s_right_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_mixed_left, m_mixed_right;

    resampling_stereo_audio_mixer #(.QUEUE_DEPTH(QDEPTH)) i_dut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_operation, .s_left_sample, .s_right_sample,
        .m_valid, .m_ready, .m_mixed_left, .m_mixed_right
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mixer model state: sample queues, period sums, phase and registers.
    logic [31:0] main_fifo[$];
    logic [31:0] coproc_fifo[$];
    logic [31:0] left_period_sum, right_period_sum;
    logic [25:0] phase;
    logic        mix_on;
    logic [23:0] step_q16;

    // Expected output samples, {right, left}.
    logic [31:0] expected_mix[$];
    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        error_count++;
    endtask

    // Signed sample times unsigned Q.16 fraction, truncated toward zero.
    function automatic logic [31:0] frac_product(input logic signed [15:0] x,
                                                 input logic [25:0] f);
        longint p;
        p = longint'(x) * longint'({1'b0, f});
        return 32'(p / 65536);
    endfunction

    function automatic logic [15:0] period_out(input logic [31:0] sum,
                                               input logic [23:0] step);
        longint q;
        q = (longint'(signed'(sum)) * 65536) / longint'({1'b0, step});
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    task automatic resample_coproc(input logic signed [15:0] l, input logic signed [15:0] r);
        logic [23:0] step;
        logic [25:0] first;
        logic [15:0] ol, orr;
        step = (step_q16 == 0) ? 24'd1 : step_q16;
        if (phase >= 26'h10000) begin
            // Whole sample falls inside the current period.
            phase -= 26'h10000;
            left_period_sum  += 32'(signed'(l));
            right_period_sum += 32'(signed'(r));
            return;
        end
        left_period_sum  += frac_product(l, phase);
        right_period_sum += frac_product(r, phase);
        ol  = period_out(left_period_sum, step);
        orr = period_out(right_period_sum, step);
        first = 26'h10000 - phase;
        left_period_sum  = frac_product(l, first);
        right_period_sum = frac_product(r, first);
        phase = ({2'b0, step} >= first) ? ({2'b0, step} - first) : '0;
        if (coproc_fifo.size() < QDEPTH) coproc_fifo.push_back({orr, ol});
    endtask

    task automatic predict_mix(input op_t op, input logic signed [15:0] l,
                               input logic signed [15:0] r);
        logic [31:0] m, c;
        logic signed [16:0] al, ar;
        if (op == OP_MAIN) begin
            if (!mix_on) begin
                expected_mix.push_back({r, l});
                return;
            end
            if (main_fifo.size() < QDEPTH) main_fifo.push_back({r, l});
        end else begin
            resample_coproc(l, r);
        end
        if (main_fifo.size() == 0 || coproc_fifo.size() == 0) return;
        m = main_fifo.pop_front();
        c = coproc_fifo.pop_front();
        al = (17'(signed'(m[15:0]))  + 17'(signed'(c[15:0])))  / 2;
        ar = (17'(signed'(m[31:16])) + 17'(signed'(c[31:16]))) / 2;
        expected_mix.push_back({ar[15:0], al[15:0]});
    endtask

    // APB write; mirrors the register effect into the model.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        s_valid <= 1'b0;
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_COPROC_ON) begin
            mix_on = data[0];
            main_fifo.delete();
            coproc_fifo.delete();
            left_period_sum = '0;
            right_period_sum = '0;
        end else if (addr == ADDR_STEP_RATIO) begin
            step_q16 = data[23:0];
            phase = '0;
        end
    endtask

    // Wait until all expected results are back, then let the block settle.
    task automatic drain;
        s_valid <= 1'b0;
        while (expected_mix.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Valid stays high after an accept until the next item or an idle cycle.
    task automatic send_item(input op_t op, input logic signed [15:0] l,
                             input logic signed [15:0] r);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_left_sample <= l;
        s_right_sample <= r;
        do @(posedge aclk); while (!s_ready);
        predict_mix(op, l, r);
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] rand_sample;
        case ($urandom_range(7, 0))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(15, 0)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Result checker and receiver back-pressure.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (recv_idle_pct == 0) || ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_mix.size() == 0) begin
                report_mismatch("unexpected item", m_mixed_left, 0);
            end else begin
                logic [31:0] e;
                e = expected_mix.pop_front();
                if (m_mixed_left !== e[15:0])
                    report_mismatch("mixed_left", m_mixed_left, signed'(e[15:0]));
                if (m_mixed_right !== e[31:16])
                    report_mismatch("mixed_right", m_mixed_right, signed'(e[31:16]));
            end
        end
    end

    task automatic test_passthrough;
        send_item(OP_MAIN, 16'sh7fff, 16'sh8000);
        send_item(OP_MAIN, 16'sh8000, 16'sh7fff);
        send_item(OP_MAIN, 16'sh0000, -16'sd1);
        // Coprocessor items while off are queued but never drained.
        send_item(OP_COPROC, 16'sh1234, -16'sd100);
        send_item(OP_MAIN, 16'sh5555, 16'shaaaa);
        drain();
    endtask

    task automatic test_directed_mix;
        write_reg(ADDR_COPROC_ON, 32'd1);
        send_item(OP_MAIN, 16'sh7fff, 16'sh8000);
        send_item(OP_COPROC, 16'sh7fff, 16'sh8000);
        send_item(OP_COPROC, -16'sd3, 16'sd3);
        send_item(OP_MAIN, -16'sd1, 16'sd1);
        send_item(OP_MAIN, 16'sh8000, 16'sh8000);
        drain();
        // Step below one, and a zero step treated as the smallest step.
        write_reg(ADDR_STEP_RATIO, 32'h0000_4000);
        repeat (3) send_item(OP_COPROC, 16'sh7fff, 16'sh8000);
        repeat (3) send_item(OP_MAIN, 16'sh0101, -16'sd257);
        drain();
        write_reg(ADDR_STEP_RATIO, 32'd0);
        repeat (3) send_item(OP_COPROC, 16'sh8000, 16'sh7fff);
        send_item(OP_MAIN, 16'sh7fff, 16'sh7fff);
        drain();
        // Largest step: many items accumulate per period.
        write_reg(ADDR_STEP_RATIO, 32'h00ff_ffff);
        repeat (4) send_item(OP_COPROC, 16'sh7fff, 16'sh7fff);
        send_item(OP_MAIN, 16'sh0001, 16'sh0001);
        drain();
    endtask

    task automatic test_full_queue;
        // Overfill the main queue; extra samples are dropped.
        write_reg(ADDR_STEP_RATIO, 32'h0001_0000);
        write_reg(ADDR_COPROC_ON, 32'd1);
        for (int i = 0; i < QDEPTH + 8; i++) send_item(OP_MAIN, 16'(i), -16'(i));
        for (int i = 0; i < QDEPTH + 8; i++) send_item(OP_COPROC, rand_sample(), rand_sample());
        drain();
    endtask

    task automatic random_phase(input int n);
        logic [23:0] steps[6] = '{24'd1, 24'h00_8000, 24'h01_0000, 24'h01_8000,
                                  24'h03_0000, 24'hff_ffff};
        logic [23:0] st;
        st = ($urandom_range(3, 0) == 0) ? 24'($urandom) : steps[$urandom_range(5, 0)];
        // Large steps need many coprocessor items per output; keep them rare.
        write_reg(ADDR_STEP_RATIO, {8'h0, st});
        write_reg(ADDR_COPROC_ON, 32'($urandom_range(7, 0) != 0));
        for (int i = 0; i < n; i++) begin
            op_t op;
            op = ($urandom_range(1, 0) == 0) ? OP_MAIN : OP_COPROC;
            send_item(op, rand_sample(), rand_sample());
        end
        drain();
    endtask

    task automatic test_random;
        send_idle_pct = 8;  recv_idle_pct = 77;
        repeat (5) random_phase(120);
        send_idle_pct = 77; recv_idle_pct = 8;
        repeat (3) random_phase(80);
        send_idle_pct = 0;  recv_idle_pct = 0;
        repeat (4) random_phase(120);
    endtask

    task automatic test_backpressure;
        // Receiver stalls long while the sender keeps offering items.
        write_reg(ADDR_STEP_RATIO, 32'h0001_0000);
        write_reg(ADDR_COPROC_ON, 32'd0);
        hold_cycles = 400;
        for (int i = 0; i < 40; i++) send_item(OP_MAIN, rand_sample(), rand_sample());
        // Sender pauses until everything has come back.
        drain();
        write_reg(ADDR_COPROC_ON, 32'd1);
        hold_cycles = 600;
        for (int i = 0; i < 60; i++)
            send_item((i % 2) ? OP_COPROC : OP_MAIN, rand_sample(), rand_sample());
        drain();
    endtask

    initial begin
        mix_on = 1'b0;
        step_q16 = 24'h01_0000;
        phase = '0;
        left_period_sum = '0;
        right_period_sum = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_passthrough();
        test_directed_mix();
        test_full_queue();
        test_backpressure();
        test_random();
        if (error_count == 0) begin
            $display("resampling_stereo_audio_mixer_tb passed");
        end else begin
            $display("resampling_stereo_audio_mixer_tb failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("resampling_stereo_audio_mixer_tb failed");
        $finish;
    end
endmodule
